### hw/rtl/integral_box_lbp_coder_unit_defines.svh
// assertion macros for the integral box lbp coder
// used by the top level only, needs nothing else
`ifndef INTEGRAL_BOX_LBP_CODER_UNIT_DEFINES_SVH
`define INTEGRAL_BOX_LBP_CODER_UNIT_DEFINES_SVH

// same-cycle implication, reset masks the check
`define IBL_ASSERT_IMP(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("integral box lbp coder: same-cycle check failed");

// next-cycle implication, reset masks the check
`define IBL_ASSERT_NXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("integral box lbp coder: next-cycle check failed");

`endif

### hw/rtl/ibl_pkg.sv
// shared types, codes and the box corner table of the integral box lbp coder
// no dependencies
`default_nettype none

package ibl_pkg;

  localparam int CoordW = 8;
  localparam int ValueW = 32;
  localparam int StepW  = 5;
  localparam int BoxW   = 3;

  // item commands
  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_QUERY4 = 2'd1,
    CMD_QUERY2 = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_SPARE2       = 2'd2,
    REG_SPARE3       = 2'd3
  } reg_idx_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_WAIT = 2'd2
  } seq_state_e;

  // corner coordinate picks: first, middle, doubled middle, last
  typedef enum logic [1:0] {
    CRD_A = 2'd0,
    CRD_M = 2'd1,
    CRD_E = 2'd2,
    CRD_B = 2'd3
  } coord_e;

  typedef struct packed {
    coord_e r0;
    coord_e r1;
    coord_e c0;
    coord_e c1;
  } box_sel_t;

  // read tag, travels with the registered memory data
  typedef struct packed {
    logic            vld;
    logic            first;
    logic            neg;
    logic            last;
    logic            fin;
    logic            mode4;
    logic [BoxW-1:0] box;
  } tag_t;

  // compare stage control
  typedef struct packed {
    logic            vld;
    logic            fin;
    logic            mode4;
    logic [BoxW-1:0] box;
  } cmp_t;

  localparam logic [BoxW-1:0]  BoxFirst  = 3'd0;
  localparam logic [BoxW-1:0]  BoxQuadHi = 3'd4;
  localparam logic [StepW-1:0] LastStep4 = 5'd19;
  localparam logic [StepW-1:0] LastStep2 = 5'd15;

  // rows and columns of each box, in the order the sequencer walks them
  function automatic box_sel_t box_sel(input logic mode4, input logic [BoxW-1:0] box);
    box_sel_t s;
    s = '{r0: CRD_A, r1: CRD_B, c0: CRD_A, c1: CRD_B};
    if (mode4) begin
      unique case (box)
        3'd1:    s = '{r0: CRD_A, r1: CRD_M, c0: CRD_A, c1: CRD_M};
        3'd2:    s = '{r0: CRD_A, r1: CRD_M, c0: CRD_M, c1: CRD_E};
        3'd3:    s = '{r0: CRD_M, r1: CRD_E, c0: CRD_M, c1: CRD_E};
        3'd4:    s = '{r0: CRD_M, r1: CRD_E, c0: CRD_A, c1: CRD_M};
        default: s = '{r0: CRD_A, r1: CRD_B, c0: CRD_A, c1: CRD_B};
      endcase
    end else begin
      unique case (box)
        3'd0:    s = '{r0: CRD_A, r1: CRD_M, c0: CRD_A, c1: CRD_B};
        3'd1:    s = '{r0: CRD_M, r1: CRD_E, c0: CRD_A, c1: CRD_B};
        3'd2:    s = '{r0: CRD_A, r1: CRD_B, c0: CRD_A, c1: CRD_M};
        3'd3:    s = '{r0: CRD_A, r1: CRD_B, c0: CRD_M, c1: CRD_E};
        default: s = '{r0: CRD_A, r1: CRD_B, c0: CRD_A, c1: CRD_B};
      endcase
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ibl_store.sv
// single-port integral image memory, registered read data
// no dependencies
`default_nettype none

module ibl_store #(
  parameter int Depth  = 16384,
  parameter int AddrW  = 14,
  parameter int ValueW = 32
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  addr_i,
  input  wire logic [ValueW-1:0] wdata_i,
  output logic      [ValueW-1:0] rdata_o
);

  logic [ValueW-1:0] mem_q [Depth];
  logic [ValueW-1:0] rdata_q;

  // one access per cycle, write has priority by use
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/ibl_seq.sv
// corner read sequencer: walks the boxes of a query, four corners each
// depends on ibl_pkg
`default_nettype none

module ibl_seq #(
  parameter int AddrW = 14
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        go_i,
  input  wire logic                        mode4_i,
  input  wire logic [ibl_pkg::CoordW-1:0]  rect_left_i,
  input  wire logic [ibl_pkg::CoordW-1:0]  rect_top_i,
  input  wire logic [ibl_pkg::CoordW-1:0]  rect_right_i,
  input  wire logic [ibl_pkg::CoordW-1:0]  rect_bottom_i,
  input  wire logic [ibl_pkg::CoordW-1:0]  img_w_i,
  input  wire logic                        fin_i,
  output logic                             busy_o,
  output logic      [AddrW-1:0]            rd_addr_o,
  output ibl_pkg::tag_t                    tag_o
);

  localparam int LinW = 2 * ibl_pkg::CoordW + 1;

  ibl_pkg::seq_state_e state_q, state_d;
  logic [ibl_pkg::StepW-1:0]  step_q, step_d;
  logic                       mode4_q;
  logic [ibl_pkg::CoordW-1:0] row_q [4];
  logic [ibl_pkg::CoordW-1:0] col_q [4];
  ibl_pkg::tag_t              tag_q, tag_d;

  logic                       issue;
  logic                       last_step;
  logic [ibl_pkg::BoxW-1:0]   box;
  logic [1:0]                 corner;
  ibl_pkg::box_sel_t          sel;
  ibl_pkg::coord_e            rsel, csel;
  logic [ibl_pkg::CoordW-1:0] row, col;
  logic [LinW-1:0]            lin;
  logic [ibl_pkg::CoordW-1:0] h2, w2, t1, l1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ibl_pkg::ST_IDLE: if (go_i) state_d = ibl_pkg::ST_READ;
      ibl_pkg::ST_READ: if (last_step) state_d = ibl_pkg::ST_WAIT;
      ibl_pkg::ST_WAIT: if (fin_i) state_d = ibl_pkg::ST_IDLE;
      default:          state_d = ibl_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    issue  = 1'b0;
    busy_o = 1'b1;
    unique case (state_q)
      ibl_pkg::ST_IDLE: busy_o = 1'b0;
      ibl_pkg::ST_READ: issue  = 1'b1;
      ibl_pkg::ST_WAIT: issue  = 1'b0;
      default:          busy_o = 1'b0;
    endcase
  end

  assign last_step = issue &&
                     (mode4_q ? (step_q == ibl_pkg::LastStep4) : (step_q == ibl_pkg::LastStep2));

  // step counter: box in the upper bits, corner in the low two
  always_comb begin
    step_d = step_q;
    if (go_i) begin
      step_d = '0;
    end else if (issue) begin
      step_d = step_q + 1'b1;
    end
  end

  // corner coordinates of the query, fixed while it runs
  always_comb begin
    h2 = (rect_bottom_i - rect_top_i) >> 1;
    w2 = (rect_right_i - rect_left_i) >> 1;
    t1 = rect_top_i - 1'b1;
    l1 = rect_left_i - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      mode4_q  <= mode4_i;
      row_q[0] <= t1;
      row_q[1] <= t1 + h2;
      row_q[2] <= t1 + {h2[ibl_pkg::CoordW-2:0], 1'b0};
      row_q[3] <= rect_bottom_i - 1'b1;
      col_q[0] <= l1;
      col_q[1] <= l1 + w2;
      col_q[2] <= l1 + {w2[ibl_pkg::CoordW-2:0], 1'b0};
      col_q[3] <= rect_right_i - 1'b1;
    end
  end

  // corner pick: far corner and near corner add, the two mixed ones subtract
  always_comb begin
    box    = step_q[ibl_pkg::StepW-1:2];
    corner = step_q[1:0];
    sel    = ibl_pkg::box_sel(mode4_q, box);
    rsel   = (corner[0] ^ corner[1]) ? sel.r0 : sel.r1;
    csel   = corner[0] ? sel.c0 : sel.c1;
    row    = row_q[rsel];
    col    = col_q[csel];
    lin    = ({{(LinW - ibl_pkg::CoordW){1'b0}}, row} *
              {{(LinW - ibl_pkg::CoordW){1'b0}}, img_w_i}) +
             {{(LinW - ibl_pkg::CoordW){1'b0}}, col};
  end

  assign rd_addr_o = AddrW'(lin);

  // tag lines up with the memory read data
  always_comb begin
    tag_d.vld   = issue;
    tag_d.first = (corner == 2'd0);
    tag_d.neg   = corner[1];
    tag_d.last  = (corner == 2'd3);
    tag_d.fin   = last_step;
    tag_d.mode4 = mode4_q;
    tag_d.box   = box;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ibl_pkg::ST_IDLE;
      step_q  <= '0;
      tag_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      tag_q   <= tag_d;
    end
  end

  assign tag_o = tag_q;

endmodule

`default_nettype wire

### hw/rtl/ibl_accum.sv
// shared add/subtract accumulator, box sum compare and result register
// depends on ibl_pkg
`default_nettype none

module ibl_accum #(
  parameter int SumBits = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ibl_pkg::tag_t               tag_i,
  input  wire logic [ibl_pkg::ValueW-1:0]  rdata_i,
  input  wire logic                        bad_i,
  output logic                             fin_o,
  output logic                             done_o,
  output logic      [3:0]                  code_o,
  output logic                             status_o
);

  localparam int CmpW = SumBits + 2;

  logic [SumBits-1:0] acc_q, acc_d;
  logic [SumBits-1:0] ref_q, ref_d;
  logic [3:0]         bits_q, bits_d;
  ibl_pkg::cmp_t      cmp_q, cmp_d;
  logic               done_q;
  logic [3:0]         code_q;
  logic               status_q;

  logic [SumBits-1:0] operand, base;
  logic [CmpW-1:0]    lhs, rhs;
  logic               gt;
  logic               take_ref;
  logic [1:0]         bit_idx;

  // accumulate one corner a cycle, modulo the sum width
  always_comb begin
    operand = SumBits'(rdata_i);
    base    = tag_i.first ? '0 : acc_q;
    acc_d   = acc_q;
    if (tag_i.vld) begin
      acc_d = tag_i.neg ? (base - operand) : (base + operand);
    end
    cmp_d.vld   = tag_i.vld & tag_i.last;
    cmp_d.fin   = tag_i.fin;
    cmp_d.mode4 = tag_i.mode4;
    cmp_d.box   = tag_i.box;
  end

  // compare a finished box sum: quadrant times four against total, or half against half
  always_comb begin
    if (cmp_q.mode4) begin
      lhs      = {acc_q, 2'b00};
      rhs      = {2'b00, ref_q};
      take_ref = (cmp_q.box == ibl_pkg::BoxFirst);
      bit_idx  = 2'(ibl_pkg::BoxQuadHi - cmp_q.box);
    end else begin
      lhs      = {2'b00, ref_q};
      rhs      = {2'b00, acc_q};
      take_ref = ~cmp_q.box[0];
      bit_idx  = {1'b0, ~cmp_q.box[1]};
    end
    gt = lhs > rhs;

    ref_d  = ref_q;
    bits_d = bits_q;
    if (cmp_q.vld) begin
      if (cmp_q.box == ibl_pkg::BoxFirst) begin
        bits_d = '0;
      end
      if (take_ref) begin
        ref_d = acc_q;
      end else begin
        bits_d[bit_idx] = gt;
      end
    end
  end

  assign fin_o = cmp_q.vld & cmp_q.fin;

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    ref_q  <= ref_d;
    bits_q <= bits_d;
    if (bad_i) begin
      code_q   <= '0;
      status_q <= 1'b1;
    end else if (fin_o) begin
      code_q   <= bits_d;
      status_q <= 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cmp_q  <= cmp_d;
      done_q <= bad_i | fin_o;
    end
  end

  assign done_o   = done_q;
  assign code_o   = code_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

### hw/rtl/integral_box_lbp_coder_unit.sv
// top level of the integral box lbp coder: config registers, command decode, store
// depends on ibl_pkg, ibl_store, ibl_seq, ibl_accum and the defines header
`default_nettype none

// Usage
// An item is taken at a rising edge with start high and busy low. cmd_i selects
// a write of one integral image entry (entry_addr_i, entry_value_i) or a 4-bit
// or 2-bit code query on the rectangle in rect_*_i. A write lands at the accepting
// edge, gives no result and leaves busy low, so writes go at one per cycle; a
// write past the store is dropped, and the unused command is ignored.
// A query raises busy and reads box corners one per cycle through the single
// memory port, each into one shared add/subtract accumulator. A 4-bit query reads
// 20 corners (five boxes) and a 2-bit query reads 16; each then strobes done_o
// with code_o and status_o. busy drops as done_o rises, so the next item may be
// taken in the strobe cycle. A rejected rectangle or image size gives status_o 1,
// code_o 0 on the next cycle. done_o is high for one cycle only; the receiver
// takes it as it comes. Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i)
// set image width and height; the user must make them while the block is idle,
// which the block itself does not enforce. Reset sets both to 128, clears the
// control state and leaves the memory contents undefined until written.

`include "integral_box_lbp_coder_unit_defines.svh"

module integral_box_lbp_coder_unit #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int SUM_BITS   = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_idx_i,
  input  wire logic [7:0]                  cfg_wdata_i,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  cmd_i,
  input  wire logic [13:0]                 entry_addr_i,
  input  wire logic [31:0]                 entry_value_i,
  input  wire logic [7:0]                  rect_left_i,
  input  wire logic [7:0]                  rect_top_i,
  input  wire logic [7:0]                  rect_right_i,
  input  wire logic [7:0]                  rect_bottom_i,
  output logic                             done_o,
  output logic      [3:0]                  code_o,
  output logic                             status_o
);

  localparam int StoreDepth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW      = $clog2(StoreDepth);

  logic [7:0]        image_width_q;
  logic [7:0]        image_height_q;

  logic              accept;
  logic              is_query;
  logic              geom_ok;
  logic              run_go;
  logic              bad_go;
  logic              wr_go;
  logic              fin;
  logic [AddrW-1:0]  rd_addr;
  logic [AddrW-1:0]  mem_addr;
  logic [31:0]       rdata;
  ibl_pkg::tag_t     tag;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= 8'd128;
      image_height_q <= 8'd128;
    end else if (cfg_we_i) begin
      unique case (ibl_pkg::reg_idx_e'(cfg_idx_i))
        ibl_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata_i;
        ibl_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // item decode and rectangle check
  always_comb begin
    accept   = start & ~busy;
    is_query = (cmd_i == ibl_pkg::CMD_QUERY4) || (cmd_i == ibl_pkg::CMD_QUERY2);
    geom_ok  = (image_width_q != '0) && (int'(image_width_q) <= MAX_WIDTH) &&
               (image_height_q != '0) && (int'(image_height_q) <= MAX_HEIGHT) &&
               (rect_left_i != '0) && (rect_top_i != '0) &&
               (rect_right_i > rect_left_i) && (rect_bottom_i > rect_top_i) &&
               (rect_right_i <= image_width_q) && (rect_bottom_i <= image_height_q);
    run_go   = accept & is_query & geom_ok;
    bad_go   = accept & is_query & ~geom_ok;
    wr_go    = accept && (cmd_i == ibl_pkg::CMD_WRITE) && (int'(entry_addr_i) < StoreDepth);
    mem_addr = wr_go ? AddrW'(entry_addr_i) : rd_addr;
  end

  ibl_store #(
    .Depth  (StoreDepth),
    .AddrW  (AddrW),
    .ValueW (ibl_pkg::ValueW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_go),
    .addr_i  (mem_addr),
    .wdata_i (entry_value_i),
    .rdata_o (rdata)
  );

  ibl_seq #(
    .AddrW (AddrW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .go_i          (run_go),
    .mode4_i       (cmd_i == ibl_pkg::CMD_QUERY4),
    .rect_left_i   (rect_left_i),
    .rect_top_i    (rect_top_i),
    .rect_right_i  (rect_right_i),
    .rect_bottom_i (rect_bottom_i),
    .img_w_i       (image_width_q),
    .fin_i         (fin),
    .busy_o        (busy),
    .rd_addr_o     (rd_addr),
    .tag_o         (tag)
  );

  ibl_accum #(
    .SumBits (SUM_BITS)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (tag),
    .rdata_i  (rdata),
    .bad_i    (bad_go),
    .fin_o    (fin),
    .done_o   (done_o),
    .code_o   (code_o),
    .status_o (status_o)
  );

  // a result only appears once the query has let go of the store
  `IBL_ASSERT_IMP(a_done_not_busy, clk_i, rst_ni, done_o, !busy)
  // an error result carries a zero code
  `IBL_ASSERT_IMP(a_status_zero_code, clk_i, rst_ni, done_o && status_o, code_o == 4'd0)
  // a taken query either runs or is rejected at once
  `IBL_ASSERT_NXT(a_query_starts, clk_i, rst_ni, accept && is_query, busy || (done_o && status_o))
  // a write neither blocks nor answers
  `IBL_ASSERT_NXT(a_write_silent, clk_i, rst_ni, wr_go, !busy && !done_o)

endmodule

`default_nettype wire
